// ===== rtl/hpe_pkg.sv =====
`timescale 1ns / 1ps
// hpe_pkg: shared types, the static huffman code table and code length helper
package hpe_pkg;

	localparam int CodeWidth  = 30;
	localparam int PendWidth  = 7;
	localparam int WordWidth  = 40;
	localparam int CountWidth = 3;

	// static huffman codes, right aligned, indexed by octet
	localparam logic [CodeWidth-1:0] CODES [256] = '{
		30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3,
		30'hfffffe4, 30'hfffffe5, 30'hfffffe6, 30'hfffffe7,
		30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
		30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec,
		30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
		30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
		30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7,
		30'hffffff8, 30'hffffff9, 30'hffffffa, 30'hffffffb,
		30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
		30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
		30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
		30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
		30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
		30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
		30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
		30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
		30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
		30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
		30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
		30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
		30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8,
		30'h3fffd3, 30'h3fffd4, 30'h3fffd5, 30'h7fffd9,
		30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc,
		30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf,
		30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0,
		30'hffffee, 30'h7fffe1, 30'h7fffe2, 30'h7fffe3,
		30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
		30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef,
		30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb,
		30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde,
		30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0,
		30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec,
		30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
		30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
		30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4,
		30'h7ffff0, 30'h3fffe5, 30'h3fffe6, 30'h7ffff1,
		30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1,
		30'h3fffe7, 30'h7ffff2, 30'h3fffe8, 30'h1ffffec,
		30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
		30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed,
		30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0,
		30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2,
		30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9,
		30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
		30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6,
		30'h3fffe9, 30'h1fffe7, 30'h1fffe8, 30'h7ffff3,
		30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef,
		30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
		30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
		30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea,
		30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed,
		30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
	};

	// packed bits for one symbol, msb first, with the number of whole bytes
	typedef struct packed {
		logic [WordWidth-1:0]  word;
		logic [CountWidth-1:0] count;
		logic                  eos;
	} pk_res_t;

	// 5-bit codes sit below 0x14, 6-bit codes below 0x2e, the rest lead with a one
	function automatic logic [4:0] code_len(input logic [CodeWidth-1:0] c);
		logic [4:0] len;
		len = 5'd5;
		if (c < 30'h14) begin
			len = 5'd5;
		end else if (c < 30'h2e) begin
			len = 5'd6;
		end else begin
			for (int i = 0; i < CodeWidth; i++) begin
				if (c[i]) begin
					len = 5'(i + 1);
				end
			end
		end
		return len;
	endfunction

endpackage

// ===== rtl/hpe_packer.sv =====
`timescale 1ns / 1ps
// hpe_packer: code lookup, merge with pending bits and end of string padding
module hpe_packer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            symbol,
	input  logic                  end_of_string,
	input  logic                  advance,
	output hpe_pkg::pk_res_t      res
);

	// pending bits kept left aligned, unused bits zero
	logic [hpe_pkg::PendWidth-1:0] pend_q;
	logic [2:0]                    pcnt_q;

	logic [hpe_pkg::CodeWidth-1:0] code;
	logic [hpe_pkg::CodeWidth-1:0] code_al;
	logic [4:0]                    len;
	logic [5:0]                    nbits;
	logic [hpe_pkg::WordWidth-1:0] merged;
	logic [hpe_pkg::WordWidth-1:0] rest;
	logic [2:0]                    full;
	logic                          pad;

	always_comb begin
		code    = hpe_pkg::CODES[symbol];
		len     = hpe_pkg::code_len(code);
		code_al = code << (5'd30 - len);
		nbits   = {3'b0, pcnt_q} + {1'b0, len};
		full    = nbits[5:3];
		pad     = end_of_string && (nbits[2:0] != 3'd0);
		merged  = {pend_q, 33'b0} | ({code_al, 10'b0} >> pcnt_q);
		rest    = merged << {full, 3'b0};
		res.word  = end_of_string ? (merged | ({hpe_pkg::WordWidth{1'b1}} >> nbits)) : merged;
		res.count = full + {2'b0, pad};
		res.eos   = end_of_string;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (advance) begin
			if (end_of_string) begin
				pend_q <= '0;
				pcnt_q <= '0;
			end else begin
				pend_q <= rest[hpe_pkg::WordWidth-1 -: hpe_pkg::PendWidth];
				pcnt_q <= nbits[2:0];
			end
		end
	end

endmodule

// ===== rtl/hpe_out_buf.sv =====
`timescale 1ns / 1ps
// hpe_out_buf: result register that hands out packed bytes one word at a time
module hpe_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  hpe_pkg::pk_res_t res,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             last_byte,
	output logic             free_next
);

	logic [hpe_pkg::WordWidth-1:0]  word_s2;
	logic [hpe_pkg::CountWidth-1:0] cnt_s2;
	logic                           eos_s2;
	logic                           take;

	assign out_valid = (cnt_s2 != '0);
	assign out_byte  = word_s2[hpe_pkg::WordWidth-1 -: 8];
	assign last_byte = out_valid && eos_s2 && (cnt_s2 == 3'd1);
	assign take      = out_valid && !out_stall;
	assign free_next = !out_valid || (take && (cnt_s2 == 3'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
			eos_s2 <= 1'b0;
		end else if (load) begin
			cnt_s2 <= res.count;
			eos_s2 <= res.eos;
		end else if (take) begin
			cnt_s2 <= cnt_s2 - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s2 <= res.word;
		end else if (take) begin
			word_s2 <= word_s2 << 8;
		end
	end

endmodule

// ===== rtl/hpack_huffman_encoder.sv =====
`timescale 1ns / 1ps
// hpack_huffman_encoder: top level of the static huffman string encoder
//
// Encodes a header string one octet per input word with the fixed hpack
// huffman code table and streams the coded string out one byte per output
// word, msb first. The octet marked end_of_string closes the string: any
// trailing partial byte is padded with ones and the final byte carries
// last_byte. An accepted octet sits in the input register, where the
// code lookup and bit merge run. If it completes a byte, it is then
// loaded into the result register, from which its 1 to 5 bytes leave
// one per cycle while out_stall is low. The result register is the
// limit: an octet occupies it until its last byte is taken, and the next
// octet that completes a byte waits in the input register until then.
// Octets that complete no byte pass straight through without waiting for
// the result register. in_stall rises only while the result register
// still holds bytes that the next octet cannot join.
module hpack_huffman_encoder (
	input  logic       clk,
	input  logic       arst_n,
	// input words: one octet of the string
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       end_of_string,
	// output words: one coded byte
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_byte
);

	// input register
	logic       valid_s1;
	logic [7:0] symbol_s1;
	logic       eos_s1;

	hpe_pkg::pk_res_t res;
	logic             free_next;
	logic             move;
	logic             in_take;

	// an octet that completes no byte only updates the pending bits
	assign move     = valid_s1 && ((res.count == '0) || free_next);
	assign in_stall = valid_s1 && !move;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			symbol_s1 <= symbol;
			eos_s1    <= end_of_string;
		end
	end

	// lookup, merge with pending bits, pad at end of string
	hpe_packer u_packer (
		.clk           (clk),
		.arst_n        (arst_n),
		.symbol        (symbol_s1),
		.end_of_string (eos_s1),
		.advance       (move),
		.res           (res)
	);

	// result register and byte serialiser
	hpe_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (move && (res.count != '0)),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.last_byte (last_byte),
		.free_next (free_next)
	);

endmodule

// ===== rtl/hpe_checker.sv =====
`timescale 1ns / 1ps
// hpe_checker: port level checks on the encoder, bound to the top level
module hpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] symbol,
	input logic       end_of_string,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_byte
);

	// a held output word keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte))
		else $error("output word changed while stalled");

	// input is only held back while bytes are waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// the end marker never shows on an empty output
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_byte |-> out_valid)
		else $error("last byte flagged without valid");

	// stall drops once the output drains its last pending byte
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output idle");

endmodule

bind hpack_huffman_encoder hpe_checker u_hpe_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking regression of the hpack huffman string encoder
module testbench;

	// run length guard, far above the slowest legal run
	localparam int CycleLimit = 200000;
	// cycles allowed after the last expected byte for any stray output
	localparam int SettleCycles = 20;

	// one coded byte as it should leave the block
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} coded_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] symbol = 8'd0;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       last_byte;

	// bytes still owed by the block, oldest first
	coded_byte_t coded_q [$];

	// bits of the current string not yet packed into a byte
	logic [6:0] held_bits = 7'd0;
	int         held_count = 0;

	// idle rates in percent, per side
	int snd_idle = 0;
	int rcv_idle = 0;
	// long receiver hold-off: request from the tests, countdown in the stall process
	int hold_req = 0;
	int hold_left = 0;

	int cycle_count = 0;
	int fail_count = 0;
	int octets_sent = 0;
	int bytes_checked = 0;
	int strings_sent = 0;

	hpack_huffman_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.symbol        (symbol),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last_byte     (last_byte)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d bytes still owed", cycle_count,
				coded_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// length of a table code: short codes are padded with leading zeros
	function automatic int huff_len(input logic [29:0] c);
		int n;
		n = 0;
		if (c < 30'h14) begin
			return 5;
		end
		if (c < 30'h2e) begin
			return 6;
		end
		for (int i = 0; i < 30; i++) begin
			if (c[i]) begin
				n = i + 1;
			end
		end
		return n;
	endfunction

	// pack one accepted octet and queue every byte it completes
	task automatic encode_octet(input logic [7:0] sym, input logic eos);
		logic [29:0] code;
		logic [36:0] acc;
		logic [7:0]  done [5];
		coded_byte_t cb;
		int          len;
		int          n;
		int          k;
		int          pad;
		code = hpe_pkg::CODES[sym];
		len  = huff_len(code);
		acc  = ({30'd0, held_bits} << len) | {7'd0, code};
		n    = held_count + len;
		k    = 0;
		// whole bytes, msb first
		while (n >= 8 && k < 5) begin
			done[k] = 8'(acc >> (n - 8));
			k++;
			n -= 8;
		end
		acc = acc & ((37'd1 << n) - 37'd1);
		if (eos) begin
			// trailing partial byte is filled with ones
			if (n > 0 && k < 5) begin
				pad     = 8 - n;
				done[k] = 8'((acc << pad) | ((37'd1 << pad) - 37'd1));
				k++;
			end
			held_bits  = 7'd0;
			held_count = 0;
		end else begin
			held_bits  = acc[6:0];
			held_count = n;
		end
		for (int i = 0; i < k; i++) begin
			cb.data = done[i];
			cb.last = eos && (i == k - 1);
			coded_q.push_back(cb);
		end
	endtask

	// one line per mismatch, counted
	task automatic report_mismatch(input string what, input int want, input int got);
		fail_count++;
		$display("mismatch at cycle %0d: %s expected 0x%02h got 0x%02h", cycle_count, what,
			want, got);
	endtask

	// input words feed the prediction, output words are checked against it
	always @(posedge clk) begin
		coded_byte_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				encode_octet(symbol, end_of_string);
			end
			if (out_valid && !out_stall) begin
				if (coded_q.size() == 0) begin
					report_mismatch("unexpected byte", 0, out_byte);
				end else begin
					want = coded_q.pop_front();
					if (out_byte !== want.data) begin
						report_mismatch("out_byte", want.data, out_byte);
					end
					if (last_byte !== want.last) begin
						report_mismatch("last_byte", want.last, last_byte);
					end
					bytes_checked++;
				end
			end
		end
	end

	// receiver: random stall, overridden by a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_idle);
		end
	end

	// offer one word and return once it has been taken; valid stays high so the
	// next word can follow without a gap
	task automatic send_octet(input logic [7:0] sym, input logic eos);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		symbol        <= sym;
		end_of_string <= eos;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		octets_sent++;
		if (eos) begin
			strings_sent++;
		end
	endtask

	// stop offering and wait until every owed byte has been taken; the first
	// edge lets the prediction of the last accepted word land first
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (coded_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// mostly printable text, now and then any octet
	function automatic logic [7:0] pick_octet(input int wide_pct);
		if ($urandom_range(0, 99) < wide_pct) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(32, 126));
	endfunction

	// random strings of 1 to 12 octets, the last string cut to fit the count
	task automatic send_strings(input int count, input int wide_pct);
		int left;
		int len;
		left = count;
		while (left > 0) begin
			len = $urandom_range(1, 12);
			if (len > left) begin
				len = left;
			end
			for (int i = 0; i < len; i++) begin
				send_octet(pick_octet(wide_pct), i == len - 1);
			end
			left -= len;
		end
	endtask

	// extremes of the table and the corner cases of string ends
	task automatic test_directed_cases;
		snd_idle = 0;
		rcv_idle = 0;
		// three 5-bit codes leave seven bits pending, then a 30-bit code ends the
		// string: four whole bytes plus a padding byte
		send_octet(8'd48, 1'b0);
		send_octet(8'd48, 1'b0);
		send_octet(8'd48, 1'b0);
		send_octet(8'd10, 1'b1);
		// a single 8-bit code ends on a byte boundary, no padding byte
		send_octet(8'd38, 1'b1);
		// 5 + 5 + 6 bits also land on a boundary
		send_octet(8'd48, 1'b0);
		send_octet(8'd48, 1'b0);
		send_octet(8'd32, 1'b1);
		// short string padded with ones
		send_octet(8'd48, 1'b1);
		// lowest and highest octets alone
		send_octet(8'd0, 1'b1);
		send_octet(8'd255, 1'b1);
		// the other 30-bit codes mid string
		send_octet(8'd13, 1'b0);
		send_octet(8'd22, 1'b0);
		send_octet(8'd49, 1'b1);
		// a run of octets that often complete no byte
		for (int i = 0; i < 7; i++) begin
			send_octet(8'd97, i == 6);
		end
		// new string straight after an end, extremes back to back
		send_octet(8'd255, 1'b0);
		send_octet(8'd0, 1'b1);
		drain();
	endtask

	// sender mostly busy, receiver often stalling
	task automatic test_receiver_sparse;
		snd_idle = 11;
		rcv_idle = 59;
		send_strings(50, 30);
	endtask

	// sender often idle, receiver mostly ready
	task automatic test_sender_sparse;
		snd_idle = 59;
		rcv_idle = 11;
		send_strings(50, 30);
	endtask

	// full rate on both sides
	task automatic test_back_to_back;
		snd_idle = 0;
		rcv_idle = 0;
		send_strings(50, 30);
	endtask

	// receiver holds off for a long stretch while long codes keep coming, so the
	// block fills up and has to stall its input
	task automatic test_output_hold;
		snd_idle = 0;
		rcv_idle = 0;
		hold_req = 80;
		send_strings(20, 100);
	endtask

	// sender pauses with nothing owed, then starts a fresh burst
	task automatic test_pause_and_drain;
		snd_idle = 11;
		rcv_idle = 11;
		send_strings(10, 50);
		drain();
		repeat (SettleCycles) @(posedge clk);
		send_strings(10, 50);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_receiver_sparse();
		test_sender_sparse();
		test_back_to_back();
		test_output_hold();
		test_pause_and_drain();

		drain();
		// any byte beyond the prediction would be flagged here
		repeat (SettleCycles) @(posedge clk);
		if (coded_q.size() != 0) begin
			report_mismatch("bytes still owed", 0, coded_q.size());
		end

		$display("encoded %0d strings from %0d octets, %0d coded bytes compared",
			strings_sent, octets_sent, bytes_checked);
		$display("covered table extremes, boundary and padded ends, stalls on both sides");
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== hpack_huffman_encoder.f =====
rtl/hpe_pkg.sv
rtl/hpe_packer.sv
rtl/hpe_out_buf.sv
rtl/hpack_huffman_encoder.sv
rtl/hpe_checker.sv
tb/testbench.sv
